// ===== rtl/dpb_pkg.sv =====
// ----------------------------------------------------------------------------
// Depth pixel back-projection package
// Shared types, register indexes and constants of the back-projection block.
// ----------------------------------------------------------------------------
package dpb_pkg;

    // Texture row pitch used for the sprite index.
    localparam int TEX_WIDTH = 1280;

    // Largest scaled depth and the depth given to a rejected point (-10000.0).
    localparam logic [30:0] DEPTH_MAX = 31'h7FFF_FFFF;
    localparam logic [31:0] REJECT_Z  = 32'hD8F0_0000;

    // Queue between the classifying front and the projecting back.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    // Configuration port.
    localparam int CFG_DW = 31;
    typedef logic [2:0] t_cfg_idx;

    localparam t_cfg_idx CFG_CENTER_X    = 3'd0;
    localparam t_cfg_idx CFG_CENTER_Y    = 3'd1;
    localparam t_cfg_idx CFG_INV_FOCAL_X = 3'd2;
    localparam t_cfg_idx CFG_INV_FOCAL_Y = 3'd3;
    localparam t_cfg_idx CFG_DEPTH_SCALE = 3'd4;
    localparam t_cfg_idx CFG_NEAR_LIMIT  = 3'd5;
    localparam t_cfg_idx CFG_FAR_LIMIT   = 3'd6;
    localparam t_cfg_idx CFG_AUTO_RANGE  = 3'd7;

    // Configuration register set.
    typedef struct packed {
        logic [15:0] center_x;
        logic [15:0] center_y;
        logic [23:0] inv_focal_x;
        logic [23:0] inv_focal_y;
        logic [23:0] depth_scale;
        logic [30:0] near_limit;
        logic [30:0] far_limit;
        logic [1:0]  auto_range;
    } t_cfg;

    // Input request: one visited pixel.
    typedef struct packed {
        logic [10:0] col_u;
        logic [9:0]  row_v;
        logic [15:0] depth_raw;
        logic [7:0]  in_blue;
        logic [7:0]  in_green;
        logic [7:0]  in_red;
        logic [7:0]  in_alpha;
        logic        frame_end;
    } t_pixel_in;

    // Output request: one point of the cloud.
    typedef struct packed {
        logic               kept;
        logic [19:0]        sprite_index;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic [7:0]         out_blue;
        logic [7:0]         out_green;
        logic [7:0]         out_red;
        logic [7:0]         out_alpha;
    } t_point_out;

    // Classified pixel handed from the front to the back.
    typedef struct packed {
        logic        kept;
        logic [19:0] sprite_index;
        logic [30:0] scaled;
        logic [27:0] t_x;
        logic [27:0] t_y;
        logic        neg_x;
        logic        neg_y;
        logic [7:0]  blue;
        logic [7:0]  green;
        logic [7:0]  red;
        logic [7:0]  alpha;
    } t_job;

    // Queue status seen by the front and the top level.
    typedef struct packed {
        logic [QUEUE_CW-1:0] count;
        logic                full;
        logic                empty;
    } t_queue_status;

endpackage

// ===== rtl/dpb_front.sv =====
// ----------------------------------------------------------------------------
// Depth pixel back-projection front end
// Scales the depth, forms the per-axis reciprocal offsets, tracks the range
// bounds and classifies each pixel before it enters the queue.
// ----------------------------------------------------------------------------
module dpb_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  dpb_pkg::t_cfg      i_cfg,
    input  logic               i_restart,
    input  logic               i_valid,
    output logic               o_stall,
    input  dpb_pkg::t_pixel_in i_data,
    input  logic               i_full,
    output logic               o_push,
    output dpb_pkg::t_job      o_job
);
    import dpb_pkg::*;

    // Stage one registers.
    logic        r_s1_vld;
    t_pixel_in   r_pix;
    logic [30:0] r_scaled;
    logic [27:0] r_tx;
    logic [27:0] r_ty;
    logic        r_neg_x;
    logic        r_neg_y;
    logic [19:0] r_index;

    // Range trackers.
    logic [30:0] r_trk_near;
    logic [30:0] r_trk_far;
    logic        r_frozen;

    logic        w_s1_load;
    logic [39:0] w_prod;
    logic [30:0] w_scaled;
    logic [15:0] w_cx;
    logic [15:0] w_cy;
    logic        w_neg_x;
    logic        w_neg_y;
    logic [15:0] w_dx;
    logic [15:0] w_dy;
    logic [39:0] w_tx_full;
    logic [39:0] w_ty_full;
    logic [31:0] w_index_full;
    logic        w_upd_near;
    logic        w_upd_far;
    logic [30:0] w_lo;
    logic [30:0] w_hi;
    logic        w_keep;

    // Stage one takes a new request whenever it is empty or its contents move on.
    assign o_push    = r_s1_vld && !i_full;
    assign w_s1_load = !r_s1_vld || o_push;
    assign o_stall   = !w_s1_load;

    // Depth scaling with saturation to the largest Q16.16 depth.
    assign w_prod   = 40'(i_data.depth_raw) * 40'(i_cfg.depth_scale);
    assign w_scaled = (w_prod[39:31] != '0) ? DEPTH_MAX : w_prod[30:0];

    // Offset from the principal point in Q12.4, kept as sign and magnitude.
    assign w_cx    = {1'b0, i_data.col_u, 4'b0000};
    assign w_cy    = {2'b00, i_data.row_v, 4'b0000};
    assign w_neg_x = w_cx < i_cfg.center_x;
    assign w_neg_y = w_cy < i_cfg.center_y;
    assign w_dx    = w_neg_x ? (i_cfg.center_x - w_cx) : (w_cx - i_cfg.center_x);
    assign w_dy    = w_neg_y ? (i_cfg.center_y - w_cy) : (w_cy - i_cfg.center_y);

    // Offset times reciprocal focal length, rounded to Q.16.
    assign w_tx_full = 40'(w_dx) * 40'(i_cfg.inv_focal_x) + 40'd2048;
    assign w_ty_full = 40'(w_dy) * 40'(i_cfg.inv_focal_y) + 40'd2048;

    // Texture slot index wraps to its field width.
    assign w_index_full = 32'(i_data.col_u) + 32'(i_data.row_v) * 32'(TEX_WIDTH);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (w_s1_load) begin
            r_s1_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_load && i_valid) begin
            r_pix    <= i_data;
            r_scaled <= w_scaled;
            r_tx     <= w_tx_full[39:12];
            r_ty     <= w_ty_full[39:12];
            r_neg_x  <= w_neg_x;
            r_neg_y  <= w_neg_y;
            r_index  <= w_index_full[19:0];
        end
    end

    // The bounds take the current pixel into account before the range test.
    assign w_upd_near = !r_frozen && i_cfg.auto_range[0] && (r_scaled < r_trk_near);
    assign w_upd_far  = !r_frozen && i_cfg.auto_range[1] && (r_scaled > r_trk_far);

    always_comb begin
        if (i_cfg.auto_range[0]) begin
            w_lo = w_upd_near ? r_scaled : r_trk_near;
        end else begin
            w_lo = i_cfg.near_limit;
        end
        if (i_cfg.auto_range[1]) begin
            w_hi = w_upd_far ? r_scaled : r_trk_far;
        end else begin
            w_hi = i_cfg.far_limit;
        end
        w_keep = (w_lo <= r_scaled) && (r_scaled <= w_hi);
    end

    // Tracker update; a write of the auto range register restarts tracking.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_restart) begin
            r_trk_near <= DEPTH_MAX;
            r_trk_far  <= '0;
            r_frozen   <= 1'b0;
        end else if (o_push) begin
            if (w_upd_near) begin
                r_trk_near <= r_scaled;
            end
            if (w_upd_far) begin
                r_trk_far <= r_scaled;
            end
            if (r_pix.frame_end) begin
                r_frozen <= 1'b1;
            end
        end
    end

    // Classified request for the queue; a rejected pixel loses its colour.
    always_comb begin
        o_job.kept         = w_keep;
        o_job.sprite_index = r_index;
        o_job.scaled       = r_scaled;
        o_job.t_x          = r_tx;
        o_job.t_y          = r_ty;
        o_job.neg_x        = r_neg_x;
        o_job.neg_y        = r_neg_y;
        o_job.blue         = w_keep ? r_pix.in_blue  : 8'd0;
        o_job.green        = w_keep ? r_pix.in_green : 8'd0;
        o_job.red          = w_keep ? r_pix.in_red   : 8'd0;
        o_job.alpha        = w_keep ? r_pix.in_alpha : 8'd0;
    end

endmodule

// ===== rtl/dpb_queue.sv =====
// ----------------------------------------------------------------------------
// Depth pixel back-projection queue
// Short first-in first-out store of classified pixels between front and back.
// ----------------------------------------------------------------------------
module dpb_queue (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  dpb_pkg::t_job          i_job,
    input  logic                   i_pop,
    output dpb_pkg::t_job          o_job,
    output dpb_pkg::t_queue_status o_status
);
    import dpb_pkg::*;

    t_job                r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr_ptr;
    logic [QUEUE_AW-1:0] r_rd_ptr;
    logic [QUEUE_CW-1:0] r_count;

    logic w_full;
    logic w_empty;
    logic w_wr;
    logic w_rd;

    assign w_full  = (r_count == QUEUE_CW'(QUEUE_DEPTH));
    assign w_empty = (r_count == '0);
    assign w_wr    = i_push && !w_full;
    assign w_rd    = i_pop && !w_empty;

    assign o_status.count = r_count;
    assign o_status.full  = w_full;
    assign o_status.empty = w_empty;
    assign o_job          = r_mem[r_rd_ptr];

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= (r_wr_ptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_rd) begin
                r_rd_ptr <= (r_rd_ptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_wr && !w_rd) begin
                r_count <= r_count + 1'b1;
            end else if (w_rd && !w_wr) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

endmodule

// ===== rtl/dpb_back.sv =====
// ----------------------------------------------------------------------------
// Depth pixel back-projection back end
// Multiplies depth by the reciprocal offsets, rounds and saturates the
// position and holds the finished point in the output register.
// ----------------------------------------------------------------------------
module dpb_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  dpb_pkg::t_job       i_job,
    input  logic                i_avail,
    output logic                o_pop,
    output logic                o_valid,
    input  logic                i_stall,
    output dpb_pkg::t_point_out o_data
);
    import dpb_pkg::*;

    // Rounds a Q.32 product to Q16.16 and applies the sign with saturation.
    function automatic logic [31:0] finish_axis(input logic [58:0] prod, input logic neg);
        logic [58:0] rounded;
        logic [42:0] mag;
        logic [31:0] lim;
        rounded = prod + 59'd32768;
        mag     = rounded[58:16];
        if (neg) begin
            lim = (mag > 43'h0_8000_0000) ? 32'h8000_0000 : mag[31:0];
            return (~lim) + 32'd1;
        end
        return (mag > 43'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
    endfunction

    logic        r_b1_vld;
    t_job        r_b1_job;
    logic [58:0] r_px;
    logic [58:0] r_py;
    logic        r_out_vld;
    t_point_out  r_out;

    logic        w_out_load;
    logic        w_b1_load;
    t_point_out  w_point;

    // Elastic two-stage pipeline towards the output register.
    assign w_out_load = !r_out_vld || !i_stall;
    assign w_b1_load  = !r_b1_vld || w_out_load;
    assign o_pop      = i_avail && w_b1_load;
    assign o_valid    = r_out_vld;
    assign o_data     = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (w_b1_load) begin
                r_b1_vld <= o_pop;
            end
            if (w_out_load) begin
                r_out_vld <= r_b1_vld;
            end
        end
    end

    // Depth times reciprocal offset for both axes.
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_b1_job <= i_job;
            r_px     <= 59'(i_job.scaled) * 59'(i_job.t_x);
            r_py     <= 59'(i_job.scaled) * 59'(i_job.t_y);
        end
    end

    // Final point; a rejected pixel sits at the far reject depth.
    always_comb begin
        w_point.kept         = r_b1_job.kept;
        w_point.sprite_index = r_b1_job.sprite_index;
        w_point.out_blue     = r_b1_job.blue;
        w_point.out_green    = r_b1_job.green;
        w_point.out_red      = r_b1_job.red;
        w_point.out_alpha    = r_b1_job.alpha;
        if (r_b1_job.kept) begin
            w_point.pos_x = finish_axis(r_px, r_b1_job.neg_x);
            w_point.pos_y = finish_axis(r_py, r_b1_job.neg_y);
            w_point.pos_z = (~{1'b0, r_b1_job.scaled}) + 32'd1;
        end else begin
            w_point.pos_x = '0;
            w_point.pos_y = '0;
            w_point.pos_z = REJECT_Z;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load && r_b1_vld) begin
            r_out <= w_point;
        end
    end

endmodule

// ===== rtl/depth_pixel_backprojection.sv =====
// A pixel accepted on the input passes the input stage, the queue, the multiply
// stage and the output register in turn before it appears on o_valid.
// Throughput: one pixel per cycle while the output is not stalled; the range tracker is a single compare loop.
// Reset (synchronous, active low) empties the pipeline and queue, loads the
// register defaults and restarts range tracking.
// ----------------------------------------------------------------------------
// Depth pixel back-projection top level
// Configuration registers, classifying front, queue and projecting back end.
// ----------------------------------------------------------------------------
module depth_pixel_backprojection (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  dpb_pkg::t_cfg_idx     i_cfg_idx,
    input  logic [dpb_pkg::CFG_DW-1:0] i_cfg_data,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  dpb_pkg::t_pixel_in    i_data,
    output logic                  o_valid,
    input  logic                  i_stall,
    output dpb_pkg::t_point_out   o_data
);
    import dpb_pkg::*;

    t_cfg          r_cfg;
    logic          w_restart;
    logic          w_push;
    logic          w_pop;
    t_job          w_front_job;
    t_job          w_queue_job;
    t_queue_status w_q_status;

    assign w_restart = i_cfg_we && (i_cfg_idx == CFG_AUTO_RANGE);

    // Configuration register writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.center_x    <= 16'd10240;
            r_cfg.center_y    <= 16'd5760;
            r_cfg.inv_focal_x <= 24'd16384;
            r_cfg.inv_focal_y <= 24'd16384;
            r_cfg.depth_scale <= 24'd65536;
            r_cfg.near_limit  <= '0;
            r_cfg.far_limit   <= DEPTH_MAX;
            r_cfg.auto_range  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_CENTER_X:    r_cfg.center_x    <= i_cfg_data[15:0];
                CFG_CENTER_Y:    r_cfg.center_y    <= i_cfg_data[15:0];
                CFG_INV_FOCAL_X: r_cfg.inv_focal_x <= i_cfg_data[23:0];
                CFG_INV_FOCAL_Y: r_cfg.inv_focal_y <= i_cfg_data[23:0];
                CFG_DEPTH_SCALE: r_cfg.depth_scale <= i_cfg_data[23:0];
                CFG_NEAR_LIMIT:  r_cfg.near_limit  <= i_cfg_data[30:0];
                CFG_FAR_LIMIT:   r_cfg.far_limit   <= i_cfg_data[30:0];
                CFG_AUTO_RANGE:  r_cfg.auto_range  <= i_cfg_data[1:0];
                default: begin
                end
            endcase
        end
    end

    // Classifying front end.
    dpb_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_restart (w_restart),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_data    (i_data),
        .i_full    (w_q_status.full),
        .o_push    (w_push),
        .o_job     (w_front_job)
    );

    // Queue between the two halves.
    dpb_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_job    (w_front_job),
        .i_pop    (w_pop),
        .o_job    (w_queue_job),
        .o_status (w_q_status)
    );

    // Projecting back end.
    dpb_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_job   (w_queue_job),
        .i_avail (!w_q_status.empty),
        .o_pop   (w_pop),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

    // The queue never holds more than its depth.
    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_status.count <= QUEUE_CW'(QUEUE_DEPTH))
        else $error("queue fill count beyond its depth");

    // The front never pushes into a full queue.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_status.full |-> !w_push)
        else $error("request pushed into a full queue");

    // A rejected point is transparent, at the origin and at the reject depth.
    a_reject_point: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_data.kept) |-> (o_data.pos_z == REJECT_Z && o_data.out_alpha == 8'd0
                                       && o_data.pos_x == '0 && o_data.pos_y == '0))
        else $error("rejected point carries position or colour");

    // A kept point never lies in front of the camera.
    a_kept_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.kept) |-> (o_data.pos_z[31] || o_data.pos_z == '0))
        else $error("kept point with positive depth");

endmodule

// ===== tb/sv/depth_pixel_backprojection_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Depth pixel back-projection testbench
// Drives pixel requests with random gaps and random output stalls, predicts
// every point of the cloud in a scoreboard and compares it field by field.
// Register settings change between phases, only while the block is drained.
// ----------------------------------------------------------------------------
module depth_pixel_backprojection_tb;

    import dpb_pkg::*;

    // Expected points of the cloud, worked out from the accepted pixels.
    class cloud_point_board;
        t_cfg        regs;
        logic [30:0] near_seen;
        logic [30:0] far_seen;
        bit          frozen;
        t_point_out  awaited_points[$];
        int          failures;

        function new();
            regs.center_x    = 16'd10240;
            regs.center_y    = 16'd5760;
            regs.inv_focal_x = 24'd16384;
            regs.inv_focal_y = 24'd16384;
            regs.depth_scale = 24'd65536;
            regs.near_limit  = 31'd0;
            regs.far_limit   = DEPTH_MAX;
            regs.auto_range  = 2'd0;
            failures         = 0;
            restart_tracking();
        endfunction

        function void restart_tracking();
            near_seen = DEPTH_MAX;
            far_seen  = 31'd0;
            frozen    = 1'b0;
        endfunction

        function void write_reg(t_cfg_idx idx, logic [CFG_DW-1:0] value);
            case (idx)
                CFG_CENTER_X:    regs.center_x    = value[15:0];
                CFG_CENTER_Y:    regs.center_y    = value[15:0];
                CFG_INV_FOCAL_X: regs.inv_focal_x = value[23:0];
                CFG_INV_FOCAL_Y: regs.inv_focal_y = value[23:0];
                CFG_DEPTH_SCALE: regs.depth_scale = value[23:0];
                CFG_NEAR_LIMIT:  regs.near_limit  = value[30:0];
                CFG_FAR_LIMIT:   regs.far_limit   = value[30:0];
                CFG_AUTO_RANGE: begin
                    regs.auto_range = value[1:0];
                    restart_tracking();
                end
                default: ;
            endcase
        endfunction

        // One axis through the pinhole: offset from the centre times 1/f times
        // depth, rounded half away from zero and saturated to 32 bits.
        function logic [31:0] back_project(logic [10:0] coord, logic [15:0] centre,
                                           logic [23:0] inv, logic [30:0] scaled);
            bit [63:0] c16;
            bit [63:0] dmag;
            bit [63:0] t;
            bit [63:0] p;
            bit        neg;
            c16  = {49'd0, coord, 4'd0};
            neg  = c16 < 64'(centre);
            dmag = neg ? 64'(centre) - c16 : c16 - 64'(centre);
            t    = (dmag * 64'(inv) + 64'd2048) >> 12;
            p    = (64'(scaled) * t + 64'd32768) >> 16;
            if (neg) begin
                if (p > 64'h8000_0000)
                    p = 64'h8000_0000;
                p = 64'd0 - p;
            end else if (p > 64'h7FFF_FFFF) begin
                p = 64'h7FFF_FFFF;
            end
            return p[31:0];
        endfunction

        function void note_pixel(t_pixel_in px);
            bit [63:0]   prod;
            logic [30:0] scaled;
            logic [30:0] lo;
            logic [30:0] hi;
            t_point_out  pt;
            prod   = 64'(px.depth_raw) * 64'(regs.depth_scale);
            scaled = (prod > 64'(DEPTH_MAX)) ? DEPTH_MAX : prod[30:0];

            // Bounds follow the first frame until its last pixel has passed.
            if (!frozen) begin
                if (regs.auto_range[0] && scaled < near_seen)
                    near_seen = scaled;
                if (regs.auto_range[1] && scaled > far_seen)
                    far_seen = scaled;
            end
            lo = regs.auto_range[0] ? near_seen : regs.near_limit;
            hi = regs.auto_range[1] ? far_seen : regs.far_limit;

            pt              = '0;
            pt.kept         = (lo <= scaled) && (scaled <= hi);
            pt.sprite_index = 20'(px.col_u + px.row_v * TEX_WIDTH);
            if (pt.kept) begin
                pt.pos_x     = back_project(px.col_u, regs.center_x, regs.inv_focal_x, scaled);
                pt.pos_y     = back_project({1'b0, px.row_v}, regs.center_y,
                                            regs.inv_focal_y, scaled);
                pt.pos_z     = 32'd0 - {1'b0, scaled};
                pt.out_blue  = px.in_blue;
                pt.out_green = px.in_green;
                pt.out_red   = px.in_red;
                pt.out_alpha = px.in_alpha;
            end else begin
                pt.pos_z = REJECT_Z;
            end

            if (px.frame_end)
                frozen = 1'b1;
            awaited_points.push_back(pt);
        endfunction

        function void compare(string name, logic signed [32:0] want, logic signed [32:0] got);
            if (got !== want) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                failures++;
            end
        endfunction

        function void check_point(t_point_out got);
            t_point_out want;
            if (awaited_points.size() == 0) begin
                $error("point with sprite index %0d arrived with none awaited",
                       got.sprite_index);
                failures++;
                return;
            end
            want = awaited_points.pop_front();
            compare("kept",         want.kept,         got.kept);
            compare("sprite_index", want.sprite_index, got.sprite_index);
            compare("pos_x",        want.pos_x,        got.pos_x);
            compare("pos_y",        want.pos_y,        got.pos_y);
            compare("pos_z",        want.pos_z,        got.pos_z);
            compare("out_blue",     want.out_blue,     got.out_blue);
            compare("out_green",    want.out_green,    got.out_green);
            compare("out_red",      want.out_red,      got.out_red);
            compare("out_alpha",    want.out_alpha,    got.out_alpha);
        endfunction

        function int pending();
            return awaited_points.size();
        endfunction
    endclass

    logic              i_clk;
    logic              i_rst_n;
    logic              i_cfg_we;
    t_cfg_idx          i_cfg_idx;
    logic [CFG_DW-1:0] i_cfg_data;
    logic              i_valid;
    logic              o_stall;
    t_pixel_in         i_data;
    logic              o_valid;
    logic              i_stall;
    t_point_out        o_data;

    cloud_point_board board;
    bit               calm;

    depth_pixel_backprojection dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_data     (i_data),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_data     (o_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Generous ceiling on the whole run.
    initial begin
        #3_000_000;
        $display("Mismatches found");
        $finish;
    end

    // Watch both channels and the register port at every edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_we)
                board.write_reg(i_cfg_idx, i_cfg_data);
            if (i_valid && !o_stall)
                board.note_pixel(i_data);
            if (o_valid && !i_stall)
                board.check_point(o_data);
        end
    end

    function automatic int draw_gap();
        return calm ? 0 : $urandom_range(0, 15);
    endfunction

    // Receiver: stall for a random gap before taking each point.
    initial begin
        int n;
        i_stall = 1'b0;
        @(posedge i_clk);
        forever begin
            n = draw_gap();
            if (n != 0) begin
                i_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            do @(posedge i_clk); while (!o_valid);
        end
    end

    task automatic send_pixel(input t_pixel_in px);
        int gap;
        gap = draw_gap();
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= px;
        do @(posedge i_clk); while (o_stall);
    endtask

    // Stop sending and wait until every awaited point has been taken.
    task automatic wait_drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (board.pending() != 0)
            @(posedge i_clk);
    endtask

    task automatic load_reg(input t_cfg_idx idx, input logic [CFG_DW-1:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
    endtask

    task automatic program_regs(input t_cfg c);
        load_reg(CFG_CENTER_X,    CFG_DW'(c.center_x));
        load_reg(CFG_CENTER_Y,    CFG_DW'(c.center_y));
        load_reg(CFG_INV_FOCAL_X, CFG_DW'(c.inv_focal_x));
        load_reg(CFG_INV_FOCAL_Y, CFG_DW'(c.inv_focal_y));
        load_reg(CFG_DEPTH_SCALE, CFG_DW'(c.depth_scale));
        load_reg(CFG_NEAR_LIMIT,  CFG_DW'(c.near_limit));
        load_reg(CFG_FAR_LIMIT,   CFG_DW'(c.far_limit));
        load_reg(CFG_AUTO_RANGE,  CFG_DW'(c.auto_range));
        i_cfg_we <= 1'b0;
    endtask

    function automatic t_pixel_in make_pixel(int col, int row, int raw, int b, int g,
                                             int r, int a, bit last);
        t_pixel_in px;
        px.col_u     = 11'(col);
        px.row_v     = 10'(row);
        px.depth_raw = 16'(raw);
        px.in_blue   = 8'(b);
        px.in_green  = 8'(g);
        px.in_red    = 8'(r);
        px.in_alpha  = 8'(a);
        px.frame_end = last;
        return px;
    endfunction

    // Mostly pixels inside the texture, now and then anywhere the fields reach.
    function automatic t_pixel_in random_pixel();
        t_pixel_in px;
        px.col_u     = ($urandom_range(0, 15) == 0) ? 11'($urandom) : 11'($urandom_range(0, 1279));
        px.row_v     = ($urandom_range(0, 15) == 0) ? 10'($urandom) : 10'($urandom_range(0, 719));
        case ($urandom_range(0, 9))
            0:       px.depth_raw = 16'($urandom_range(0, 3));
            1:       px.depth_raw = 16'($urandom_range(65532, 65535));
            default: px.depth_raw = 16'($urandom);
        endcase
        px.in_blue   = 8'($urandom);
        px.in_green  = 8'($urandom);
        px.in_red    = 8'($urandom);
        px.in_alpha  = 8'($urandom);
        px.frame_end = ($urandom_range(0, 39) == 0);
        return px;
    endfunction

    function automatic logic [30:0] scale_depth(logic [15:0] raw, logic [23:0] scale);
        bit [63:0] prod;
        prod = 64'(raw) * 64'(scale);
        return (prod > 64'(DEPTH_MAX)) ? DEPTH_MAX : prod[30:0];
    endfunction

    // Register set for one random phase; the first three are the extremes.
    function automatic t_cfg random_cfg(int phase);
        t_cfg        c;
        logic [31:0] span;
        case (phase)
            0: begin
                c = '{16'hFFFF, 16'hFFFF, 24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF,
                      31'd0, DEPTH_MAX, 2'd0};
            end
            1: begin
                c = '0;
            end
            2: begin
                c = '{16'd0, 16'd0, 24'($urandom), 24'($urandom), 24'hFF_FFFF,
                      DEPTH_MAX, DEPTH_MAX, 2'd0};
            end
            default: begin
                c.center_x    = ($urandom_range(0, 7) == 0) ? 16'($urandom)
                                                            : 16'($urandom_range(8000, 12400));
                c.center_y    = ($urandom_range(0, 7) == 0) ? 16'($urandom)
                                                            : 16'($urandom_range(4000, 7500));
                c.inv_focal_x = ($urandom_range(0, 7) == 0) ? 24'($urandom)
                                                            : 24'($urandom_range(8000, 60000));
                c.inv_focal_y = ($urandom_range(0, 7) == 0) ? 24'($urandom)
                                                            : 24'($urandom_range(8000, 60000));
                case ($urandom_range(0, 7))
                    0:       c.depth_scale = 24'hFF_FFFF;
                    1:       c.depth_scale = 24'($urandom);
                    2:       c.depth_scale = 24'd65536;
                    default: c.depth_scale = 24'($urandom_range(1000, 200000));
                endcase
                case ($urandom_range(0, 7))
                    0:       c.near_limit = 31'd0;
                    1:       c.near_limit = DEPTH_MAX;
                    2:       c.near_limit = 31'($urandom);
                    default: c.near_limit = scale_depth(16'($urandom_range(0, 40000)),
                                                        c.depth_scale);
                endcase
                case ($urandom_range(0, 7))
                    0:       c.far_limit = DEPTH_MAX;
                    1:       c.far_limit = 31'd0;
                    2:       c.far_limit = 31'($urandom);
                    default: begin
                        span = {1'b0, c.near_limit}
                             + {1'b0, scale_depth(16'($urandom_range(0, 30000)),
                                                  c.depth_scale)};
                        c.far_limit = span[31] ? DEPTH_MAX : span[30:0];
                    end
                endcase
                c.auto_range = 2'($urandom_range(0, 3));
            end
        endcase
        return c;
    endfunction

    initial begin
        t_cfg c;
        board      = new();
        calm       = 1'b0;
        i_rst_n    = 1'b0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = CFG_CENTER_X;
        i_cfg_data = '0;
        i_valid    = 1'b0;
        i_data     = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: corners of the texture, zero and full depth, the
        // principal point itself, coordinates beyond the texture.
        send_pixel(make_pixel(0, 0, 0, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0));
        send_pixel(make_pixel(1279, 719, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0));
        send_pixel(make_pixel(2047, 1023, 16'h1234, 8'h5A, 8'hA5, 8'h3C, 8'hC3, 1'b1));
        send_pixel(make_pixel(640, 360, 100, 8'h11, 8'h22, 8'h33, 8'h44, 1'b0));

        // Largest scale and reciprocals: depth and both axes saturate on the first pixel.
        wait_drain();
        c = '{16'd0, 16'hFFFF, 24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF, 31'd0, DEPTH_MAX, 2'd0};
        program_regs(c);
        send_pixel(make_pixel(2047, 0, 16'hFFFF, 8'h01, 8'h02, 8'h03, 8'h04, 1'b0));
        send_pixel(make_pixel(0, 1023, 1, 8'h80, 8'h40, 8'h20, 8'h10, 1'b0));
        send_pixel(make_pixel(1, 1, 0, 8'hFE, 8'hFD, 8'hFB, 8'hF7, 1'b0));

        // Fixed range: below, on and above each bound.
        wait_drain();
        c = '{16'd10240, 16'd5760, 24'd27962, 24'd27962, 24'd65536,
              31'(1000 << 16), 31'(5000 << 16), 2'd0};
        program_regs(c);
        send_pixel(make_pixel(100, 50, 999, 8'h10, 8'h20, 8'h30, 8'h40, 1'b0));
        send_pixel(make_pixel(900, 600, 1000, 8'h10, 8'h20, 8'h30, 8'h40, 1'b0));
        send_pixel(make_pixel(320, 700, 5000, 8'h10, 8'h20, 8'h30, 8'h40, 1'b0));
        send_pixel(make_pixel(1200, 10, 5001, 8'h10, 8'h20, 8'h30, 8'h40, 1'b0));
        send_pixel(make_pixel(640, 360, 0, 8'h10, 8'h20, 8'h30, 8'h40, 1'b0));

        // Both bounds track the first frame, then stay frozen.
        wait_drain();
        c.auto_range = 2'd3;
        program_regs(c);
        send_pixel(make_pixel(10, 10, 3000, 8'h21, 8'h22, 8'h23, 8'h24, 1'b0));
        send_pixel(make_pixel(20, 20, 2000, 8'h31, 8'h32, 8'h33, 8'h34, 1'b0));
        send_pixel(make_pixel(30, 30, 4000, 8'h41, 8'h42, 8'h43, 8'h44, 1'b1));
        send_pixel(make_pixel(40, 40, 1999, 8'h51, 8'h52, 8'h53, 8'h54, 1'b0));
        send_pixel(make_pixel(50, 50, 4001, 8'h61, 8'h62, 8'h63, 8'h64, 1'b0));
        send_pixel(make_pixel(60, 60, 2500, 8'h71, 8'h72, 8'h73, 8'h74, 1'b0));
        send_pixel(make_pixel(70, 70, 2000, 8'h81, 8'h82, 8'h83, 8'h84, 1'b1));

        // Random phases, each under its own register set.
        for (int phase = 0; phase < 11; phase++) begin
            wait_drain();
            program_regs(random_cfg(phase));
            calm = (phase % 4 == 3);
            for (int k = 0; k < 105; k++) begin
                if (phase == 5 && k == 50)
                    wait_drain();
                send_pixel(random_pixel());
            end
        end

        calm = 1'b0;
        wait_drain();
        repeat (8) @(posedge i_clk);
        if (board.failures == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
